// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and field offsets for the sorted priority queue.
// No dependencies; used by the top level, the step unit and the checker.

package spq_pkg;

    localparam int unsigned DEFAULT_DEPTH = 128;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PRIO_W  = 16;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned CNT_W   = 8;

    // Input tdata layout, lowest bit first.
    localparam int unsigned IN_FUNC_LSB  = 0;
    localparam int unsigned IN_VALUE_LSB = IN_FUNC_LSB + FUNC_W;
    localparam int unsigned IN_PRIO_LSB  = IN_VALUE_LSB + VALUE_W;
    localparam int unsigned IN_BITS      = IN_PRIO_LSB + PRIO_W;
    localparam int unsigned IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int unsigned OUT_VALUE_LSB = 0;
    localparam int unsigned OUT_STAT_LSB  = OUT_VALUE_LSB + VALUE_W;
    localparam int unsigned OUT_OCC_LSB   = OUT_STAT_LSB + STAT_W;
    localparam int unsigned OUT_REM_LSB   = OUT_OCC_LSB + CNT_W;
    localparam int unsigned OUT_BITS      = OUT_REM_LSB + CNT_W;
    localparam int unsigned OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ = 2'd0,
        FUNC_DEQ = 2'd1,
        FUNC_REM = 2'd2,
        FUNC_NOP = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RSVD  = 2'd3
    } status_t;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // Decision of the step unit for one stored entry.
    typedef struct packed {
        logic   we;        // write the memory this step
        entry_t wdata;     // data to write
        logic   inserted;  // enqueue: new entry already placed
        entry_t carry;     // enqueue: entry displaced toward the tail
        logic   keep;      // remove: entry survives, advance write pointer
        logic   grab;      // dequeue: capture the front value
    } step_t;

endpackage

// ===== hdl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Top level of the sorted priority queue: entry memory, sequencer, output register.
// Depends on spq_pkg and spq_step.
//
//   Channel  Direction  Signals                    Contents
//   s_       in         s_tvalid s_tready s_tdata  func, value, priority_req
//   m_       out        m_tvalid m_tready m_tdata  out_value, status, occupancy,
//                                                  removed_count
//
// One operation walks the held entries in order, each one read, then compared and
// written back, through a single-port-read, single-port-write memory. Rejected
// operations and those on an empty queue skip the walk.
// Reset is synchronous and active low; it empties the queue without touching
// the memory. s_tready is high only while no operation is in flight; a finished
// result waits in the output register, so a new operation may run while m_tready
// is low, but it cannot hand over its result until the previous one is taken.

module sorted_priority_queue #(
    parameter int unsigned DEPTH = spq_pkg::DEFAULT_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0 up: func[2], value[32], priority_req[16], zero pad.
    input  logic [spq_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0 up: out_value[32], status[2], occupancy[8],
    // removed_count[8], zero pad.
    output logic [spq_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PAD_W = spq_pkg::OUT_DATA_W - spq_pkg::OUT_BITS;

    // One-hot sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_PROC = 5'b00100,
        ST_LAST = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Entry memory: one write and one registered read per cycle.
    spq_pkg::entry_t mem [DEPTH];
    spq_pkg::entry_t rdata_reg;
    logic            we;
    logic [AW-1:0]   waddr;
    spq_pkg::entry_t wdata;

    // Operation context.
    spq_pkg::func_t                func_reg, func_next;
    logic [spq_pkg::PRIO_W-1:0]    prio_reg, prio_next;
    spq_pkg::entry_t               carry_reg, carry_next;
    logic                          ins_reg, ins_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 wr_reg, wr_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [spq_pkg::VALUE_W-1:0]   outv_reg, outv_next;
    spq_pkg::status_t              stat_reg, stat_next;
    logic [CW-1:0]                 rem_reg, rem_next;

    // Output register.
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [spq_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    spq_pkg::step_t step;
    logic [CW-1:0]  idx_inc;
    logic           last_entry;
    logic [CW-1:0]  wr_step;

    spq_pkg::func_t in_func;
    assign in_func = spq_pkg::func_t'(s_tdata[spq_pkg::IN_FUNC_LSB +: spq_pkg::FUNC_W]);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    spq_step u_step (
        .func     (func_reg),
        .prio_req (prio_reg),
        .first    (idx_reg == '0),
        .rd_entry (rdata_reg),
        .carry    (carry_reg),
        .inserted (ins_reg),
        .step     (step)
    );

    assign idx_inc    = CW'(idx_reg) + CW'(1);
    assign last_entry = (idx_inc == count_reg);
    assign wr_step    = step.keep ? (wr_reg + CW'(1)) : wr_reg;

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        prio_next     = prio_reg;
        carry_next    = carry_reg;
        ins_next      = ins_reg;
        idx_next      = idx_reg;
        wr_next       = wr_reg;
        count_next    = count_reg;
        outv_next     = outv_reg;
        stat_next     = stat_reg;
        rem_next      = rem_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        we            = 1'b0;
        waddr         = idx_reg;
        wdata         = step.wdata;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next        = in_func;
                    prio_next        = s_tdata[spq_pkg::IN_PRIO_LSB +: spq_pkg::PRIO_W];
                    carry_next.prio  = s_tdata[spq_pkg::IN_PRIO_LSB +: spq_pkg::PRIO_W];
                    carry_next.value = s_tdata[spq_pkg::IN_VALUE_LSB +: spq_pkg::VALUE_W];
                    ins_next         = 1'b0;
                    idx_next         = '0;
                    wr_next          = '0;
                    outv_next        = '0;
                    stat_next        = spq_pkg::STAT_OK;
                    rem_next         = '0;
                    state_next       = ST_FIN;
                    unique case (in_func)
                        spq_pkg::FUNC_ENQ: begin
                            if (count_reg == CW'(DEPTH)) begin
                                stat_next = spq_pkg::STAT_FULL;
                            end else if (count_reg == '0) begin
                                state_next = ST_LAST;
                            end else begin
                                state_next = ST_RD;
                            end
                        end
                        spq_pkg::FUNC_DEQ: begin
                            if (count_reg == '0) begin
                                stat_next = spq_pkg::STAT_EMPTY;
                            end else begin
                                state_next = ST_RD;
                            end
                        end
                        spq_pkg::FUNC_REM: begin
                            if (count_reg != '0) begin
                                state_next = ST_RD;
                            end
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RD: begin
                state_next = ST_PROC;
            end
            ST_PROC: begin
                we         = step.we;
                ins_next   = step.inserted;
                carry_next = step.carry;
                wr_next    = wr_step;
                if (step.grab) begin
                    outv_next = rdata_reg.value;
                end
                unique case (func_reg)
                    spq_pkg::FUNC_DEQ: waddr = idx_reg - AW'(1);
                    spq_pkg::FUNC_REM: waddr = wr_reg[AW-1:0];
                    default:           waddr = idx_reg;
                endcase
                if (last_entry) begin
                    unique case (func_reg)
                        spq_pkg::FUNC_ENQ: begin
                            state_next = ST_LAST;
                        end
                        spq_pkg::FUNC_DEQ: begin
                            count_next = count_reg - CW'(1);
                            state_next = ST_FIN;
                        end
                        default: begin
                            count_next = wr_step;
                            rem_next   = count_reg - wr_step;
                            state_next = ST_FIN;
                        end
                    endcase
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_RD;
                end
            end
            ST_LAST: begin
                // The new entry, or the last displaced one, lands at the tail.
                we         = 1'b1;
                waddr      = count_reg[AW-1:0];
                wdata      = carry_reg;
                count_next = count_reg + CW'(1);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}},
                                     spq_pkg::CNT_W'(rem_reg),
                                     spq_pkg::CNT_W'(count_reg),
                                     stat_reg,
                                     outv_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        prio_reg    <= prio_next;
        carry_reg   <= carry_next;
        ins_reg     <= ins_next;
        idx_reg     <= idx_next;
        wr_reg      <= wr_next;
        outv_reg    <= outv_next;
        stat_reg    <= stat_next;
        rem_reg     <= rem_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== hdl/spq_step.sv =====
`timescale 1ns / 1ps
// Per-entry decision unit of the sorted priority queue, shared by all operations.
// Depends on spq_pkg.

module spq_step (
    input  spq_pkg::func_t             func,
    input  logic [spq_pkg::PRIO_W-1:0] prio_req,
    input  logic                       first,
    input  spq_pkg::entry_t            rd_entry,
    input  spq_pkg::entry_t            carry,
    input  logic                       inserted,
    output spq_pkg::step_t             step
);

    logic hit;
    logic match;

    // Strictly lower priority: equal priorities stay ahead of the new entry.
    assign hit   = !inserted && ($signed(rd_entry.prio) < $signed(prio_req));
    assign match = (rd_entry.prio == prio_req);

    always_comb begin
        step          = '0;
        step.inserted = inserted;
        step.carry    = carry;
        step.wdata    = rd_entry;
        unique case (func)
            spq_pkg::FUNC_ENQ: begin
                step.inserted = inserted | hit;
                if (inserted | hit) begin
                    step.we    = 1'b1;
                    step.wdata = carry;
                    step.carry = rd_entry;
                end
            end
            spq_pkg::FUNC_DEQ: begin
                step.grab = first;
                step.we   = !first;
            end
            spq_pkg::FUNC_REM: begin
                step.keep = !match;
                step.we   = !match;
            end
            default: begin
                step.we = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/spq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg.

module spq_checker #(
    parameter int unsigned DEPTH = spq_pkg::DEFAULT_DEPTH
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [spq_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [spq_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic [spq_pkg::VALUE_W-1:0] o_value;
    logic [spq_pkg::STAT_W-1:0]  o_stat;
    logic [spq_pkg::CNT_W-1:0]   o_occ;
    logic [spq_pkg::CNT_W-1:0]   o_rem;
    logic                        in_any;

    assign o_value = m_tdata[spq_pkg::OUT_VALUE_LSB +: spq_pkg::VALUE_W];
    assign o_stat  = m_tdata[spq_pkg::OUT_STAT_LSB +: spq_pkg::STAT_W];
    assign o_occ   = m_tdata[spq_pkg::OUT_OCC_LSB +: spq_pkg::CNT_W];
    assign o_rem   = m_tdata[spq_pkg::OUT_REM_LSB +: spq_pkg::CNT_W];
    assign in_any  = ^s_tdata | 1'b1;

    // A stalled result transfer holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The block takes one operation at a time.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && in_any |=> !s_tready)
        else $error("input accepted while an operation is in flight");

    // A rejected enqueue reports a full queue and nothing else.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (o_stat == spq_pkg::STAT_FULL) |->
            (o_value == '0) && (o_rem == '0) &&
            ((DEPTH > 255) || (o_occ == spq_pkg::CNT_W'(DEPTH))))
        else $error("full status with inconsistent fields");

    // An empty dequeue leaves an empty queue and returns zero.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (o_stat == spq_pkg::STAT_EMPTY) |->
            (o_value == '0) && (o_occ == '0) && (o_rem == '0))
        else $error("empty status with inconsistent fields");

    // Occupancy never exceeds capacity.
    a_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (DEPTH > 255) || (o_occ <= spq_pkg::CNT_W'(DEPTH)))
        else $error("occupancy above capacity");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
